// ===== sv/mec_pkg.sv =====
package mec_pkg;

    // Default sizes of the datapath.
    localparam int FRAC_BITS_DEF  = 28;
    localparam int INDEX_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF = 16;

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_ZOOM           = 3'd0,
        REG_OFFSET_X       = 3'd1,
        REG_OFFSET_Y       = 3'd2,
        REG_WIDTH_PX       = 3'd3,
        REG_HEIGHT_PX      = 3'd4,
        REG_MAX_ITERATIONS = 3'd5,
        REG_SPARE_6        = 3'd6,
        REG_SPARE_7        = 3'd7
    } reg_idx_t;

    // Reset values of the registers.
    localparam logic [30:0] ZOOM_RST           = 31'd1073742;
    localparam logic [31:0] OFFSET_X_RST       = 32'hF800_0000;
    localparam logic [31:0] OFFSET_Y_RST       = 32'h0000_0000;
    localparam logic [12:0] WIDTH_PX_RST       = 13'd1024;
    localparam logic [12:0] HEIGHT_PX_RST      = 13'd1024;
    localparam logic [15:0] MAX_ITERATIONS_RST = 16'd256;

    // Register contents handed from the register file to the datapath.
    typedef struct packed {
        logic [30:0]        zoom;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic [12:0]        width_px;
        logic [12:0]        height_px;
        logic [15:0]        max_iterations;
    } cfg_t;

endpackage

// ===== sv/mec_cfg.sv =====
module mec_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mec_pkg::ADDR_W-1:0]        paddr,
    input  logic [mec_pkg::DATA_W-1:0]        pwdata,
    output logic [mec_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    output mec_pkg::cfg_t                     cfg
);

    mec_pkg::cfg_t     cfg_reg;
    mec_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = mec_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zoom           <= mec_pkg::ZOOM_RST;
            cfg_reg.offset_x       <= mec_pkg::OFFSET_X_RST;
            cfg_reg.offset_y       <= mec_pkg::OFFSET_Y_RST;
            cfg_reg.width_px       <= mec_pkg::WIDTH_PX_RST;
            cfg_reg.height_px      <= mec_pkg::HEIGHT_PX_RST;
            cfg_reg.max_iterations <= mec_pkg::MAX_ITERATIONS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                mec_pkg::REG_ZOOM:           cfg_reg.zoom           <= pwdata[30:0];
                mec_pkg::REG_OFFSET_X:       cfg_reg.offset_x       <= pwdata;
                mec_pkg::REG_OFFSET_Y:       cfg_reg.offset_y       <= pwdata;
                mec_pkg::REG_WIDTH_PX:       cfg_reg.width_px       <= pwdata[12:0];
                mec_pkg::REG_HEIGHT_PX:      cfg_reg.height_px      <= pwdata[12:0];
                mec_pkg::REG_MAX_ITERATIONS: cfg_reg.max_iterations <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read data, zero extended.
    always_comb
    begin
        unique case (idx)
            mec_pkg::REG_ZOOM:           prdata = {1'b0, cfg_reg.zoom};
            mec_pkg::REG_OFFSET_X:       prdata = cfg_reg.offset_x;
            mec_pkg::REG_OFFSET_Y:       prdata = cfg_reg.offset_y;
            mec_pkg::REG_WIDTH_PX:       prdata = {19'd0, cfg_reg.width_px};
            mec_pkg::REG_HEIGHT_PX:      prdata = {19'd0, cfg_reg.height_px};
            mec_pkg::REG_MAX_ITERATIONS: prdata = {16'd0, cfg_reg.max_iterations};
            default:                     prdata = '0;
        endcase
    end

endmodule

// ===== sv/mec_mul.sv =====
module mec_mul
#(
    parameter int OPW = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [OPW-1:0]   a,
    input  logic [OPW-1:0]   b,
    output logic             done,
    output logic [2*OPW-1:0] prod
);

    // Operands are split into two halves; four partial products per product.
    localparam int H         = (OPW + 1) / 2;
    localparam int HW        = 2 * H;
    localparam int AW        = 2 * HW;
    localparam logic [2:0] LAST_STEP = 3'd4;

    logic [HW-1:0] a_reg;
    logic [HW-1:0] b_reg;
    logic [HW-1:0] pp_reg;
    logic [1:0]    pp_sh_reg;
    logic [AW-1:0] acc_reg;
    logic [2:0]    step_reg;
    logic          run_reg;
    logic          pp_vld_reg;
    logic          done_reg;

    logic [H-1:0]  a_half;
    logic [H-1:0]  b_half;
    logic [HW-1:0] pp_next;
    logic [AW-1:0] pp_aligned;

    // Select the halves for this step and form one partial product.
    always_comb
    begin
        a_half  = step_reg[1] ? a_reg[HW-1:H] : a_reg[H-1:0];
        b_half  = step_reg[0] ? b_reg[HW-1:H] : b_reg[H-1:0];
        pp_next = HW'(a_half) * HW'(b_half);
    end

    // Align the registered partial product for accumulation.
    always_comb
    begin
        unique case (pp_sh_reg)
            2'd0:    pp_aligned = AW'(pp_reg);
            2'd1:    pp_aligned = AW'(pp_reg) << H;
            default: pp_aligned = AW'(pp_reg) << HW;
        endcase
    end

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            step_reg   <= '0;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg    <= 1'b1;
                step_reg   <= '0;
                pp_vld_reg <= 1'b0;
            end
            else if (run_reg)
            begin
                if (step_reg == LAST_STEP)
                begin
                    run_reg    <= 1'b0;
                    pp_vld_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    step_reg   <= step_reg + 3'd1;
                    pp_vld_reg <= 1'b1;
                end
            end
        end
    end

    // Operands, partial product and accumulator.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= HW'(a);
            b_reg   <= HW'(b);
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            if (step_reg != LAST_STEP)
            begin
                pp_reg    <= pp_next;
                pp_sh_reg <= {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
            end
            if (pp_vld_reg)
            begin
                acc_reg <= acc_reg + pp_aligned;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg[2*OPW-1:0];

    // A new product is only requested while the unit is free.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("multiplier started while busy");

    // Completion is a single-cycle pulse that ends a run.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg && $past(run_reg))
        else $error("multiplier done without a run");

endmodule

// ===== sv/mandelbrot_escape_count.sv =====
// Channel   | Signals                                   | Direction | Handshake
// ----------+-------------------------------------------+-----------+----------------------
// config    | psel penable pwrite paddr pwdata prdata   | in/out    | APB, pready always 1
// pixel in  | pixel_x pixel_y                           | in        | start high, busy low
// result    | escape_count                              | out       | result_valid pulse
//
// A product on the shared multiplier is built from four half-width partial products,
// and each iteration needs three products plus the S_CHECK and S_TEST states of
// test and update, so that unit sets how long an item takes.
// busy stays high from the accepted item until the result pulse; a new item
// may be started in the cycle of the result pulse. The receiver cannot stall.
// Reset is asynchronous and active low and returns the registers to defaults.
module mandelbrot_escape_count
#(
    parameter int FRAC_BITS  = mec_pkg::FRAC_BITS_DEF,
    parameter int INDEX_BITS = mec_pkg::INDEX_BITS_DEF,
    parameter int COUNT_BITS = mec_pkg::COUNT_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mec_pkg::ADDR_W-1:0]  paddr,
    input  logic [mec_pkg::DATA_W-1:0]  pwdata,
    output logic [mec_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic [INDEX_BITS-1:0]       pixel_x,
    input  logic [INDEX_BITS-1:0]       pixel_y,
    output logic                        result_valid,
    output logic [COUNT_BITS-1:0]       escape_count
);

    localparam int VAL = FRAC_BITS + 4;
    localparam int OPW = (VAL > 32) ? VAL : 32;
    localparam int PW  = 2 * OPW;
    localparam int WW  = PW + 2;
    localparam int DW  = (INDEX_BITS + 2 > 14) ? INDEX_BITS + 2 : 14;
    localparam int LW  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    localparam logic signed [WW-1:0] SAT_HI = {{(WW-VAL+1){1'b0}}, {(VAL-1){1'b1}}};
    localparam logic signed [WW-1:0] SAT_LO = {{(WW-VAL+1){1'b1}}, {(VAL-1){1'b0}}};
    localparam logic [PW:0]          FOUR   = (PW+1)'(1) << (2 * FRAC_BITS + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COORD_X,
        S_COORD_Y,
        S_CHECK,
        S_SQ_R,
        S_SQ_I,
        S_TEST,
        S_CROSS
    } state_t;

    mec_pkg::cfg_t cfg;

    state_t                 state_reg;
    logic [INDEX_BITS-1:0]  py_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  limit_reg;
    logic                   neg_reg;
    logic [VAL-1:0]         cr_reg;
    logic [VAL-1:0]         ci_reg;
    logic [VAL-1:0]         zr_reg;
    logic [VAL-1:0]         zi_reg;
    logic [PW-1:0]          r2_reg;
    logic [PW-1:0]          i2_reg;
    logic                   mul_start_reg;
    logic [OPW-1:0]         mul_a_reg;
    logic [OPW-1:0]         mul_b_reg;
    logic                   result_valid_reg;
    logic [COUNT_BITS-1:0]  escape_count_reg;

    logic                   mul_done;
    logic [PW-1:0]          mul_prod;

    logic signed [DW-1:0]   diff_x;
    logic signed [DW-1:0]   diff_y;
    logic [LW-1:0]          max_ext;
    logic [LW-1:0]          cmax_ext;
    logic [COUNT_BITS-1:0]  limit_calc;
    logic signed [WW-1:0]   prod_w;
    logic signed [WW-1:0]   half_w;
    logic signed [WW-1:0]   off_w;
    logic [VAL-1:0]         coord_val;
    logic signed [WW-1:0]   real_w;
    logic signed [WW-1:0]   cross_w;
    logic [VAL-1:0]         zr_upd;
    logic [VAL-1:0]         zi_upd;
    logic [PW:0]            mag2;
    logic                   escaped;

    // Saturate a wide signed value to the coordinate range.
    function automatic logic [VAL-1:0] sat_fn(input logic signed [WW-1:0] v);
        logic [VAL-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[VAL-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[VAL-1:0];
        else
            r = v[VAL-1:0];
        return r;
    endfunction

    // Magnitude of a coordinate, as a multiplier operand.
    function automatic logic [OPW-1:0] mag_fn(input logic [VAL-1:0] v);
        logic [VAL-1:0] m;
        m = v[VAL-1] ? (~v + 1'b1) : v;
        return OPW'(m);
    endfunction

    // Magnitude of a pixel offset, as a multiplier operand.
    function automatic logic [OPW-1:0] dmag_fn(input logic [DW-1:0] v);
        logic [DW-1:0] m;
        m = v[DW-1] ? (~v + 1'b1) : v;
        return OPW'(m);
    endfunction

    mec_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mec_mul #(.OPW(OPW)) u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Pixel offsets from the image center, in half pixels.
    always_comb
    begin
        diff_x = $signed(DW'({pixel_x, 1'b0})) - $signed(DW'(cfg.width_px));
        diff_y = $signed(DW'({py_reg, 1'b0})) - $signed(DW'(cfg.height_px));
    end

    // Iteration limit, clamped to what the count can hold.
    always_comb
    begin
        max_ext    = LW'(cfg.max_iterations);
        cmax_ext   = LW'({COUNT_BITS{1'b1}});
        limit_calc = (max_ext < cmax_ext) ? max_ext[COUNT_BITS-1:0]
                                          : cmax_ext[COUNT_BITS-1:0];
    end

    // Coordinate: offset plus half the scaled pixel offset, floor rounding.
    always_comb
    begin
        prod_w    = $signed({2'b00, mul_prod});
        half_w    = neg_reg ? -((prod_w + WW'(1)) >>> 1) : (prod_w >>> 1);
        off_w     = (state_reg == S_COORD_X) ? WW'($signed(cfg.offset_x))
                                             : WW'($signed(cfg.offset_y));
        coord_val = sat_fn(half_w + off_w);
    end

    // Escape test and next iterate.
    always_comb
    begin
        mag2    = {1'b0, r2_reg} + {1'b0, i2_reg};
        escaped = !(mag2 < FOUR);
        real_w  = ($signed({2'b00, r2_reg}) - $signed({2'b00, i2_reg})) >>> FRAC_BITS;
        zr_upd  = sat_fn(real_w + WW'($signed(cr_reg)));
        cross_w = neg_reg ? -$signed({2'b00, mul_prod}) : $signed({2'b00, mul_prod});
        zi_upd  = sat_fn((cross_w >>> (FRAC_BITS - 1)) + WW'($signed(ci_reg)));
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            py_reg           <= '0;
            count_reg        <= '0;
            limit_reg        <= '0;
            neg_reg          <= 1'b0;
            cr_reg           <= '0;
            ci_reg           <= '0;
            zr_reg           <= '0;
            zi_reg           <= '0;
            r2_reg           <= '0;
            i2_reg           <= '0;
            mul_start_reg    <= 1'b0;
            mul_a_reg        <= '0;
            mul_b_reg        <= '0;
            result_valid_reg <= 1'b0;
            escape_count_reg <= '0;
        end
        else
        begin
            mul_start_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        py_reg        <= pixel_y;
                        limit_reg     <= limit_calc;
                        count_reg     <= '0;
                        neg_reg       <= diff_x[DW-1];
                        mul_a_reg     <= dmag_fn(diff_x);
                        mul_b_reg     <= OPW'(cfg.zoom);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_COORD_X;
                    end
                end
                S_COORD_X:
                begin
                    if (mul_done)
                    begin
                        cr_reg        <= coord_val;
                        neg_reg       <= diff_y[DW-1];
                        mul_a_reg     <= dmag_fn(diff_y);
                        mul_b_reg     <= OPW'(cfg.zoom);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_COORD_Y;
                    end
                end
                S_COORD_Y:
                begin
                    if (mul_done)
                    begin
                        ci_reg    <= coord_val;
                        zi_reg    <= coord_val;
                        zr_reg    <= cr_reg;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (count_reg == limit_reg)
                    begin
                        result_valid_reg <= 1'b1;
                        escape_count_reg <= count_reg;
                        state_reg        <= S_IDLE;
                    end
                    else
                    begin
                        mul_a_reg     <= mag_fn(zr_reg);
                        mul_b_reg     <= mag_fn(zr_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_SQ_R;
                    end
                end
                S_SQ_R:
                begin
                    if (mul_done)
                    begin
                        r2_reg        <= mul_prod;
                        mul_a_reg     <= mag_fn(zi_reg);
                        mul_b_reg     <= mag_fn(zi_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_SQ_I;
                    end
                end
                S_SQ_I:
                begin
                    if (mul_done)
                    begin
                        i2_reg    <= mul_prod;
                        state_reg <= S_TEST;
                    end
                end
                S_TEST:
                begin
                    if (escaped)
                    begin
                        result_valid_reg <= 1'b1;
                        escape_count_reg <= count_reg;
                        state_reg        <= S_IDLE;
                    end
                    else
                    begin
                        count_reg     <= count_reg + 1'b1;
                        neg_reg       <= zr_reg[VAL-1] ^ zi_reg[VAL-1];
                        mul_a_reg     <= mag_fn(zr_reg);
                        mul_b_reg     <= mag_fn(zi_reg);
                        mul_start_reg <= 1'b1;
                        zr_reg        <= zr_upd;
                        state_reg     <= S_CROSS;
                    end
                end
                S_CROSS:
                begin
                    if (mul_done)
                    begin
                        zi_reg    <= zi_upd;
                        state_reg <= S_CHECK;
                    end
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign escape_count = escape_count_reg;

    // A result only follows an item in progress.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(state_reg != S_IDLE))
        else $error("result without an item in progress");

    // The count never passes the clamped limit.
    a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (count_reg <= limit_reg))
        else $error("iteration count beyond limit");

    // The multiplier is only started while an item is in progress.
    a_mul_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start_reg |-> (state_reg != S_IDLE))
        else $error("multiplier started while idle");

endmodule

// ===== verif/mandelbrot_escape_count_tb.sv =====
`timescale 1ns / 1ps

module mandelbrot_escape_count_tb;

    localparam int FRAC     = mec_pkg::FRAC_BITS_DEF;
    localparam int VAL_BITS = FRAC + 4;

    localparam longint Q_MAX = (64'sd1 <<< (VAL_BITS - 1)) - 64'sd1;
    localparam longint Q_MIN = -Q_MAX - 64'sd1;
    localparam logic signed [127:0] ESCAPE_RADIUS_SQ = 128'sd1 <<< (2 * FRAC + 2);

    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int RANDOM_ITEMS    = NUM_PHASES * ITEMS_PER_PHASE;

    typedef enum logic {
        PLAN_WRITE,
        PLAN_PIXEL
    } plan_kind_t;

    // One row of the directed table: a register write or a pixel.
    typedef struct packed {
        plan_kind_t        kind;
        mec_pkg::reg_idx_t target;
        logic [31:0]       value;
        logic [11:0]       px;
        logic [11:0]       py;
        logic              known;
        logic [15:0]       count;
    } plan_row_t;

    // One escape count still owed by the block.
    typedef struct packed {
        logic [11:0] px;
        logic [11:0] py;
        logic [15:0] count;
        logic        at_limit;
    } pixel_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [mec_pkg::ADDR_W-1:0]   paddr = '0;
    logic [mec_pkg::DATA_W-1:0]   pwdata = '0;
    logic [mec_pkg::DATA_W-1:0]   prdata;
    logic                         pready;
    logic                         start = 1'b0;
    logic                         busy;
    logic [11:0]                  pixel_x = '0;
    logic [11:0]                  pixel_y = '0;
    logic                         result_valid;
    logic [15:0]                  escape_count;

    mec_pkg::cfg_t       model_cfg;
    pixel_result_t       pending_counts[$];
    plan_row_t           directed_plan[$];
    int                  errors = 0;
    int                  items_sent = 0;
    int                  counts_checked = 0;
    int                  counts_at_limit = 0;
    int                  cfg_writes = 0;

    mandelbrot_escape_count i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .result_valid (result_valid),
        .escape_count (escape_count)
    );

    always #5 clk = ~clk;

    // Saturate to the signed Q4.28 range.
    function automatic longint clamp_q(input longint v);
        if (v > Q_MAX)
        begin
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            return Q_MIN;
        end
        return v;
    endfunction

    // Point on one axis: offset plus half of (2*index - size) * zoom, halved toward minus infinity.
    function automatic longint pixel_coord(input logic [11:0] idx, input logic [12:0] size,
                                           input logic signed [31:0] offs,
                                           input logic [30:0] pitch);
        longint li;
        longint ls;
        longint lp;
        longint base;
        li = idx;
        ls = size;
        lp = pitch;
        base = offs;
        return clamp_q(base + (((2 * li) - ls) * lp >>> 1));
    endfunction

    // Escape-time count of one pixel under the given register settings.
    function automatic logic [15:0] escape_time(input mec_pkg::cfg_t c, input logic [11:0] px,
                                                input logic [11:0] py);
        longint cr;
        longint ci;
        longint zr;
        longint zi;
        logic signed [127:0] wr;
        logic signed [127:0] wi;
        logic signed [127:0] r2;
        logic signed [127:0] i2;
        int n;
        int lim;
        cr = pixel_coord(px, c.width_px, c.offset_x, c.zoom);
        ci = pixel_coord(py, c.height_px, c.offset_y, c.zoom);
        zr = cr;
        zi = ci;
        n = 0;
        lim = c.max_iterations;
        while (n < lim)
        begin
            wr = zr;
            wi = zi;
            r2 = wr * wr;
            i2 = wi * wi;
            if (r2 + i2 >= ESCAPE_RADIUS_SQ)
            begin
                break;
            end
            n++;
            zr = clamp_q(longint'((r2 - i2) >>> FRAC) + cr);
            zi = clamp_q(longint'((wr * wi) >>> (FRAC - 1)) + ci);
        end
        return 16'(n);
    endfunction

    // Keep the field bits of a register value and fill the rest with noise.
    function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
        logic [31:0] mask;
        mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
        return (value & mask) | ($urandom & ~mask);
    endfunction

    // Sizes lean small but hit the edges of the field now and then.
    function automatic logic [12:0] pick_size();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0:       return 13'd1;
            1:       return 13'd4096;
            2:       return 13'd0;
            3:       return 13'd8191;
            default: return 13'($urandom_range(2, 640));
        endcase
    endfunction

    // Mostly inside the image, sometimes anywhere in the index range.
    function automatic logic [11:0] pick_index(input logic [12:0] size);
        int top;
        top = (size > 13'd4096) ? 4096 : int'(size);
        if (top >= 1 && $urandom_range(0, 4) != 0)
        begin
            return 12'($urandom_range(0, top - 1));
        end
        return 12'($urandom_range(0, 4095));
    endfunction

    // APB write; the register model follows the write.
    task automatic reg_write(input mec_pkg::reg_idx_t idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            mec_pkg::REG_ZOOM:           model_cfg.zoom = data[30:0];
            mec_pkg::REG_OFFSET_X:       model_cfg.offset_x = data;
            mec_pkg::REG_OFFSET_Y:       model_cfg.offset_y = data;
            mec_pkg::REG_WIDTH_PX:       model_cfg.width_px = data[12:0];
            mec_pkg::REG_HEIGHT_PX:      model_cfg.height_px = data[12:0];
            mec_pkg::REG_MAX_ITERATIONS: model_cfg.max_iterations = data[15:0];
            default:                     ;
        endcase
        cfg_writes++;
    endtask

    // Read every register back and compare its field bits with the model.
    task automatic check_registers();
        mec_pkg::reg_idx_t idx;
        logic [31:0]       rd;
        logic [31:0]       want;
        logic [31:0]       mask;
        for (int i = 0; i <= int'(mec_pkg::REG_MAX_ITERATIONS); i++)
        begin
            idx = mec_pkg::reg_idx_t'(i);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= {idx, 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            rd = prdata;
            psel <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
            case (idx)
                mec_pkg::REG_ZOOM:
                begin
                    want = {1'b0, model_cfg.zoom};
                    mask = 32'h7FFF_FFFF;
                end
                mec_pkg::REG_OFFSET_X:
                begin
                    want = model_cfg.offset_x;
                    mask = 32'hFFFF_FFFF;
                end
                mec_pkg::REG_OFFSET_Y:
                begin
                    want = model_cfg.offset_y;
                    mask = 32'hFFFF_FFFF;
                end
                mec_pkg::REG_WIDTH_PX:
                begin
                    want = {19'd0, model_cfg.width_px};
                    mask = 32'h0000_1FFF;
                end
                mec_pkg::REG_HEIGHT_PX:
                begin
                    want = {19'd0, model_cfg.height_px};
                    mask = 32'h0000_1FFF;
                end
                default:
                begin
                    want = {16'd0, model_cfg.max_iterations};
                    mask = 32'h0000_FFFF;
                end
            endcase
            if ((rd & mask) !== (want & mask))
            begin
                $error("register %s: expected %h, got %h", idx.name(), want & mask, rd & mask);
                errors++;
            end
        end
    endtask

    // Offer one pixel until it is taken, then queue its expected count.
    // With no gap, start stays high for the next pixel or for drain_pixels.
    task automatic send_pixel(input logic [11:0] x, input logic [11:0] y, input logic known,
                              input logic [15:0] known_count, input int gap);
        pixel_result_t entry;
        start <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        entry.px = x;
        entry.py = y;
        entry.count = known ? known_count : escape_time(model_cfg, x, y);
        entry.at_limit = (entry.count == model_cfg.max_iterations);
        pending_counts.push_back(entry);
        items_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering pixels and wait until every count owed has come back.
    task automatic drain_pixels();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_counts.size() != 0);
    endtask

    task automatic plan_write(input mec_pkg::reg_idx_t idx, input logic [31:0] value);
        plan_row_t row;
        row = '0;
        row.kind = PLAN_WRITE;
        row.target = idx;
        row.value = value;
        directed_plan.push_back(row);
    endtask

    task automatic plan_pixel(input logic [11:0] x, input logic [11:0] y, input logic known,
                              input logic [15:0] count);
        plan_row_t row;
        row = '0;
        row.kind = PLAN_PIXEL;
        row.px = x;
        row.py = y;
        row.known = known;
        row.count = count;
        directed_plan.push_back(row);
    endtask

    // Every result pulse must match the oldest count still owed.
    always @(posedge clk)
    begin : result_monitor
        pixel_result_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (pending_counts.size() == 0)
            begin
                $error("escape_count: result %0d with no pixel outstanding", escape_count);
                errors++;
            end
            else
            begin
                want = pending_counts.pop_front();
                counts_checked++;
                if (want.at_limit)
                begin
                    counts_at_limit++;
                end
                if (escape_count !== want.count)
                begin
                    $error("escape_count for pixel (%0d,%0d): expected %0d, got %0d",
                           want.px, want.py, want.count, escape_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t   row;
        logic [12:0] w;
        logic [12:0] h;
        longint      w_eff;
        longint      zoom_base;
        longint      ox;
        longint      oy;
        logic [30:0] zoom_val;
        logic [15:0] limit_val;
        int          idle_pct;
        int          gap;
        int          item_no;

        model_cfg.zoom = mec_pkg::ZOOM_RST;
        model_cfg.offset_x = mec_pkg::OFFSET_X_RST;
        model_cfg.offset_y = mec_pkg::OFFSET_Y_RST;
        model_cfg.width_px = mec_pkg::WIDTH_PX_RST;
        model_cfg.height_px = mec_pkg::HEIGHT_PX_RST;
        model_cfg.max_iterations = mec_pkg::MAX_ITERATIONS_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_registers();

        // Directed table. Default view: center at -0.5, pitch about 1/250, limit 256.
        plan_pixel(12'd512, 12'd512, 1'b1, 16'd256);
        plan_pixel(12'd0, 12'd0, 1'b1, 16'd0);
        plan_pixel(12'd4095, 12'd4095, 1'b1, 16'd0);
        plan_pixel(12'd4095, 12'd0, 1'b0, 16'd0);
        plan_pixel(12'd0, 12'd4095, 1'b0, 16'd0);
        plan_pixel(12'd1000, 12'd300, 1'b0, 16'd0);
        // A zero limit gives zero; a limit of one stops after the first test.
        plan_write(mec_pkg::REG_MAX_ITERATIONS, 32'd0);
        plan_pixel(12'd512, 12'd512, 1'b1, 16'd0);
        plan_write(mec_pkg::REG_MAX_ITERATIONS, 32'd1);
        plan_pixel(12'd512, 12'd512, 1'b1, 16'd1);
        plan_pixel(12'd0, 12'd0, 1'b1, 16'd0);
        // Zero zoom puts every pixel on the image center.
        plan_write(mec_pkg::REG_MAX_ITERATIONS, 32'd20);
        plan_write(mec_pkg::REG_ZOOM, 32'd0);
        plan_pixel(12'd4095, 12'd0, 1'b1, 16'd20);
        plan_pixel(12'd0, 12'd4095, 1'b1, 16'd20);
        // Exactly on the radius the test fails; one step inside it passes.
        plan_write(mec_pkg::REG_OFFSET_X, 32'hE000_0000);
        plan_pixel(12'd123, 12'd456, 1'b1, 16'd0);
        plan_write(mec_pkg::REG_OFFSET_X, 32'hE000_0001);
        plan_pixel(12'd7, 12'd9, 1'b0, 16'd0);
        // Extreme offsets.
        plan_write(mec_pkg::REG_OFFSET_X, 32'h7FFF_FFFF);
        plan_write(mec_pkg::REG_OFFSET_Y, 32'h8000_0000);
        plan_pixel(12'd0, 12'd0, 1'b1, 16'd0);
        // Largest zoom on a one-pixel image: an odd product halved toward minus infinity.
        plan_write(mec_pkg::REG_ZOOM, 32'h7FFF_FFFF);
        plan_write(mec_pkg::REG_OFFSET_X, 32'd0);
        plan_write(mec_pkg::REG_OFFSET_Y, 32'd0);
        plan_write(mec_pkg::REG_WIDTH_PX, 32'd1);
        plan_write(mec_pkg::REG_HEIGHT_PX, 32'd1);
        plan_pixel(12'd0, 12'd0, 1'b1, 16'd0);
        plan_pixel(12'd1, 12'd1, 1'b1, 16'd0);
        // Smallest zoom: the point lands one step off the origin.
        plan_write(mec_pkg::REG_ZOOM, 32'd1);
        plan_pixel(12'd0, 12'd0, 1'b1, 16'd20);
        plan_pixel(12'd4095, 12'd4095, 1'b0, 16'd0);
        // Largest image with the largest zoom saturates both coordinates.
        plan_write(mec_pkg::REG_WIDTH_PX, 32'd4096);
        plan_write(mec_pkg::REG_HEIGHT_PX, 32'd4096);
        plan_write(mec_pkg::REG_ZOOM, 32'h7FFF_FFFF);
        plan_pixel(12'd0, 12'd4095, 1'b1, 16'd0);
        // Writes to the spare addresses must leave the settings alone.
        plan_write(mec_pkg::REG_ZOOM, 32'h0040_0000);
        plan_write(mec_pkg::REG_SPARE_6, 32'hFFFF_FFFF);
        plan_pixel(12'd2048, 12'd2048, 1'b0, 16'd0);
        plan_write(mec_pkg::REG_SPARE_7, 32'hFFFF_FFFF);
        plan_pixel(12'd2100, 12'd1990, 1'b0, 16'd0);
        // Largest limit on a point that escapes after one iteration.
        plan_write(mec_pkg::REG_MAX_ITERATIONS, 32'd65535);
        plan_write(mec_pkg::REG_OFFSET_X, 32'h1000_0000);
        plan_write(mec_pkg::REG_ZOOM, 32'd0);
        plan_pixel(12'd3000, 12'd17, 1'b1, 16'd1);

        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.kind == PLAN_WRITE)
            begin
                drain_pixels();
                reg_write(row.target, row.value);
            end
            else
            begin
                send_pixel(row.px, row.py, row.known, row.count, $urandom_range(0, 2));
            end
        end
        drain_pixels();
        check_registers();

        // Random phases: new settings each phase, then a batch of pixels.
        item_no = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            w = pick_size();
            h = pick_size();
            w_eff = (w == 13'd0) ? 64'sd1 : longint'(w);
            zoom_base = 64'sd805306368 / w_eff;
            ox = -64'sd469762048 + longint'($urandom_range(0, 536870912));
            oy = -64'sd268435456 + longint'($urandom_range(0, 536870912));
            zoom_val = 31'(zoom_base + longint'($urandom_range(0, 31'(zoom_base / 4))));
            limit_val = ($urandom_range(0, 9) == 0) ? 16'd1 : 16'($urandom_range(2, 48));
            case (phase)
                1:
                begin
                    // Right of the set every point escapes fast, so the top limit is cheap.
                    ox = 64'sd268435456;
                    oy = 64'sd0;
                    zoom_val = 31'(64'sd107374182 / w_eff);
                    limit_val = 16'd65535;
                end
                3:
                begin
                    zoom_val = 31'h7FFF_FFFF;
                    ox = longint'(signed'(32'($urandom)));
                    oy = longint'(signed'(32'($urandom)));
                end
                5:
                begin
                    zoom_val = 31'd0;
                end
                7:
                begin
                    ox = 64'sd2147483647;
                    oy = -64'sd2147483648;
                end
                default:
                begin
                end
            endcase
            reg_write(mec_pkg::REG_ZOOM, with_junk({1'b0, zoom_val}, 31));
            reg_write(mec_pkg::REG_OFFSET_X, 32'(ox));
            reg_write(mec_pkg::REG_OFFSET_Y, 32'(oy));
            reg_write(mec_pkg::REG_WIDTH_PX, with_junk({19'd0, w}, 13));
            reg_write(mec_pkg::REG_HEIGHT_PX, with_junk({19'd0, h}, 13));
            reg_write(mec_pkg::REG_MAX_ITERATIONS, with_junk({16'd0, limit_val}, 16));
            check_registers();

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Sender idles 13 percent, then 47 percent, then not at all.
                if (item_no < RANDOM_ITEMS / 3)
                begin
                    idle_pct = 13;
                end
                else if (item_no < (2 * RANDOM_ITEMS) / 3)
                begin
                    idle_pct = 47;
                end
                else
                begin
                    idle_pct = 0;
                end
                gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 40) : 0;
                send_pixel(pick_index(model_cfg.width_px), pick_index(model_cfg.height_px),
                           1'b0, 16'd0, gap);
                item_no++;
            end
            drain_pixels();
        end

        // Nothing more should come out once the last count is in.
        repeat (100) @(posedge clk);

        $display("Sent %0d pixels across %0d register writes and %0d random settings.",
                 items_sent, cfg_writes, NUM_PHASES);
        $display("Checked %0d counts: %0d ran to the iteration limit, %0d escaped earlier.",
                 counts_checked, counts_at_limit, counts_checked - counts_at_limit);
        if (errors == 0)
        begin
            $display("mandelbrot_escape_count regression: pass");
        end
        else
        begin
            $display("mandelbrot_escape_count regression: fail");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial
    begin : watchdog
        #50_000_000;
        $display("mandelbrot_escape_count regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mec_pkg.sv
sv/mec_cfg.sv
sv/mec_mul.sv
sv/mandelbrot_escape_count.sv
verif/mandelbrot_escape_count_tb.sv
